>>> rtl/smma_pkg.sv
// ----------------------------------------------------------------------------
// smma_pkg: shared definitions for the sparse matrix merge-add block
// Request, status and configuration codes, controller states and the command
// and status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package smma_pkg;

    localparam int CAPACITY    = 32;
    localparam int INDEX_WIDTH = 8;
    localparam int VALUE_WIDTH = 16;

    // request kinds
    localparam logic [1:0] REQ_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] REQ_LOAD_SECOND = 2'd1;
    localparam logic [1:0] REQ_ADD         = 2'd2;
    localparam logic [1:0] REQ_CLEAR       = 2'd3;

    // result status codes
    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_ZERO     = 3'd1;
    localparam logic [2:0] STS_RANGE    = 3'd2;
    localparam logic [2:0] STS_DUP      = 3'd3;
    localparam logic [2:0] STS_FULL     = 3'd4;
    localparam logic [2:0] STS_MISMATCH = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_ROWS_FIRST  = 2'd0;
    localparam logic [1:0] CFG_COLS_FIRST  = 2'd1;
    localparam logic [1:0] CFG_ROWS_SECOND = 2'd2;
    localparam logic [1:0] CFG_COLS_SECOND = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_FULL_CHK,
        ST_SH_RD,
        ST_SH_WR,
        ST_MRG_RD,
        ST_MRG_EV,
        ST_MRG_END,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_STATUS,  // one result without an entry, last set
        EMIT_PEND,    // pending merge entry, last clear
        EMIT_FINAL    // pending entry with last set, or the empty marker
    } emit_t;

    typedef struct packed {
        logic       in_ready;
        logic       capture;
        logic       clear_tables;
        logic       idx_zero;
        logic       idx_inc;
        logic       idx_dec;
        logic       scan_read;
        logic       set_pos;
        logic       shift_read;
        logic       shift_write;
        logic       insert;
        logic       mrg_init;
        logic       mrg_read;
        logic       mrg_step;
        emit_t      emit;
        logic [2:0] emit_code;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req_kind;
        logic       range_bad;
        logic       value_zero;
        logic       dims_mismatch;
        logic       scan_more;
        logic       key_eq;
        logic       key_gt;
        logic       tab_full;
        logic       sh_more;
        logic       mrg_more;
        logic       mrg_nonzero;
        logic       pend_valid;
        logic       out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> rtl/sparse_matrix_merge_add.sv
// ----------------------------------------------------------------------------
// sparse_matrix_merge_add: sparse matrix addition by coordinate merge
// Loads two sorted entry tables and streams out their key-ordered sum.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel: s_tuser holds the request kind, s_tdata
//   the row, column and value of a load. Results leave on the m_ channel, one
//   per load, clear or mismatched add, or one per nonzero sum entry of an add
//   (a single empty marker when there are none); m_tlast marks the final one.
//   Dimensions are written through cfg_we/cfg_addr/cfg_data while idle.
//   One request is worked at a time; s_tready is high only between requests.
//   After acceptance, a load decodes the request, compares stored entries in
//   order up to the first larger key or the table end, checks for a full
//   table, shifts each larger entry up by a read and a write and then writes
//   the new entry; an add merges entries until both tables are spent, then
//   emits the final result; a clear or a mismatched add goes from decode
//   straight to its result. The next request is taken in the cycle after the
//   final result. Each entry is read in one state and worked in the next, as
//   the table RAMs have a registered read. The result register frees its slot
//   in the cycle m_tready takes it, so the next request may be accepted while
//   a result waits; a stalled receiver holds the sequencer at its next emit.
//   Reset empties both tables and zeroes the dimension registers; the table
//   RAMs need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_matrix_merge_add #(
    parameter int CAPACITY    = smma_pkg::CAPACITY,
    parameter int INDEX_WIDTH = smma_pkg::INDEX_WIDTH,
    parameter int VALUE_WIDTH = smma_pkg::VALUE_WIDTH,
    localparam int IN_W  = ((2 * INDEX_WIDTH + VALUE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((2 * INDEX_WIDTH + VALUE_WIDTH + 8) / 8) * 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_addr,
    input  wire logic [INDEX_WIDTH:0]   cfg_data,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // s_tdata: entry_row, entry_col, entry_value
    input  wire logic [IN_W-1:0]        s_tdata,
    // s_tuser: req_type
    input  wire logic [1:0]             s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // m_tdata: out_row, out_col, out_value
    output logic [OUT_W-1:0]            m_tdata,
    // m_tuser: status, entry_valid
    output logic [3:0]                  m_tuser,
    output logic                        m_tlast
);

    localparam int IW = INDEX_WIDTH;
    localparam int VW = VALUE_WIDTH;

    smma_pkg::cmd_t cmd;
    smma_pkg::sts_t sts;

    logic [2:0]    o_status;
    logic [IW-1:0] o_row, o_col;
    logic [VW:0]   o_value;
    logic          o_entry_valid;

    smma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    smma_dp #(
        .CAPACITY    (CAPACITY),
        .INDEX_WIDTH (INDEX_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data),
        .in_req_type     (s_tuser),
        .in_row          (s_tdata[IW-1:0]),
        .in_col          (s_tdata[2*IW-1:IW]),
        .in_value        (s_tdata[2*IW+VW-1:2*IW]),
        .cmd             (cmd),
        .sts             (sts),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_status      (o_status),
        .out_row         (o_row),
        .out_col         (o_col),
        .out_value       (o_value),
        .out_entry_valid (o_entry_valid),
        .out_last        (m_tlast)
    );

    assign s_tready = cmd.in_ready;
    assign m_tdata  = OUT_W'({o_value, o_col, o_row});
    assign m_tuser  = {o_entry_valid, o_status};

    // checks on sequencer and datapath
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit != smma_pkg::EMIT_NONE) |-> sts.out_free)
        else $error("result emitted while output slot busy");

    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> !sts.tab_full)
        else $error("insert into a full table");

    a_idle_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (cmd.emit == smma_pkg::EMIT_NONE))
        else $error("emit while accepting a request");

    a_accept_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request accepted back to back");

endmodule

`default_nettype wire

>>> rtl/smma_ram.sv
// ----------------------------------------------------------------------------
// smma_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds between reads.
// ----------------------------------------------------------------------------
`default_nettype none

module smma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/smma_ctrl.sv
// ----------------------------------------------------------------------------
// smma_ctrl: sequencer for loads, merges and clears
// Walks the sorted-insert and merge sequences and issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module smma_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire smma_pkg::sts_t sts,
    output smma_pkg::cmd_t      cmd
);

    smma_pkg::state_t state_reg, state_next;
    logic [2:0]       code_reg, code_next;

    // state and pending status code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smma_pkg::ST_IDLE;
            code_reg  <= smma_pkg::STS_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        code_next     = code_reg;
        cmd           = '0;
        cmd.emit      = smma_pkg::EMIT_NONE;
        cmd.emit_code = code_reg;
        unique case (state_reg)
            smma_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = smma_pkg::ST_DECODE;
                end
            end
            smma_pkg::ST_DECODE:
            begin
                unique case (sts.req_kind)
                    smma_pkg::REQ_LOAD_FIRST, smma_pkg::REQ_LOAD_SECOND:
                    begin
                        priority if (sts.range_bad)
                        begin
                            code_next  = smma_pkg::STS_RANGE;
                            state_next = smma_pkg::ST_RESP;
                        end
                        else if (sts.value_zero)
                        begin
                            code_next  = smma_pkg::STS_ZERO;
                            state_next = smma_pkg::ST_RESP;
                        end
                        else
                        begin
                            cmd.idx_zero = 1'b1;
                            state_next   = smma_pkg::ST_SCAN_RD;
                        end
                    end
                    smma_pkg::REQ_ADD:
                    begin
                        if (sts.dims_mismatch)
                        begin
                            code_next  = smma_pkg::STS_MISMATCH;
                            state_next = smma_pkg::ST_RESP;
                        end
                        else
                        begin
                            cmd.mrg_init = 1'b1;
                            state_next   = smma_pkg::ST_MRG_RD;
                        end
                    end
                    default:
                    begin
                        cmd.clear_tables = 1'b1;
                        code_next        = smma_pkg::STS_OK;
                        state_next       = smma_pkg::ST_RESP;
                    end
                endcase
            end
            smma_pkg::ST_SCAN_RD:
            begin
                if (sts.scan_more)
                begin
                    cmd.scan_read = 1'b1;
                    state_next    = smma_pkg::ST_SCAN_EV;
                end
                else
                begin
                    cmd.set_pos = 1'b1;
                    state_next  = smma_pkg::ST_FULL_CHK;
                end
            end
            smma_pkg::ST_SCAN_EV:
            begin
                priority if (sts.key_eq)
                begin
                    code_next  = smma_pkg::STS_DUP;
                    state_next = smma_pkg::ST_RESP;
                end
                else if (sts.key_gt)
                begin
                    cmd.set_pos = 1'b1;
                    state_next  = smma_pkg::ST_FULL_CHK;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = smma_pkg::ST_SCAN_RD;
                end
            end
            smma_pkg::ST_FULL_CHK:
            begin
                if (sts.tab_full)
                begin
                    code_next  = smma_pkg::STS_FULL;
                    state_next = smma_pkg::ST_RESP;
                end
                else
                begin
                    state_next = smma_pkg::ST_SH_RD;
                end
            end
            smma_pkg::ST_SH_RD:
            begin
                if (sts.sh_more)
                begin
                    cmd.shift_read = 1'b1;
                    state_next     = smma_pkg::ST_SH_WR;
                end
                else
                begin
                    cmd.insert = 1'b1;
                    code_next  = smma_pkg::STS_OK;
                    state_next = smma_pkg::ST_RESP;
                end
            end
            smma_pkg::ST_SH_WR:
            begin
                cmd.shift_write = 1'b1;
                cmd.idx_dec     = 1'b1;
                state_next      = smma_pkg::ST_SH_RD;
            end
            smma_pkg::ST_MRG_RD:
            begin
                if (sts.mrg_more)
                begin
                    cmd.mrg_read = 1'b1;
                    state_next   = smma_pkg::ST_MRG_EV;
                end
                else
                begin
                    state_next = smma_pkg::ST_MRG_END;
                end
            end
            smma_pkg::ST_MRG_EV:
            begin
                // a new nonzero entry pushes out the pending one
                if (!(sts.mrg_nonzero && sts.pend_valid && !sts.out_free))
                begin
                    if (sts.mrg_nonzero && sts.pend_valid)
                    begin
                        cmd.emit = smma_pkg::EMIT_PEND;
                    end
                    cmd.mrg_step = 1'b1;
                    state_next   = smma_pkg::ST_MRG_RD;
                end
            end
            smma_pkg::ST_MRG_END:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = smma_pkg::EMIT_FINAL;
                    state_next = smma_pkg::ST_IDLE;
                end
            end
            smma_pkg::ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = smma_pkg::EMIT_STATUS;
                    state_next = smma_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = smma_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/smma_dp.sv
// ----------------------------------------------------------------------------
// smma_dp: tables, counters, comparators and result register
// Holds both sorted tables in RAM and performs the compare and sum work.
// ----------------------------------------------------------------------------
`default_nettype none

module smma_dp #(
    parameter int CAPACITY    = smma_pkg::CAPACITY,
    parameter int INDEX_WIDTH = smma_pkg::INDEX_WIDTH,
    parameter int VALUE_WIDTH = smma_pkg::VALUE_WIDTH,
    localparam int IW = INDEX_WIDTH,
    localparam int VW = VALUE_WIDTH,
    localparam int DW = IW + 1
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_addr,
    input  wire logic [DW-1:0]  cfg_data,
    input  wire logic [1:0]     in_req_type,
    input  wire logic [IW-1:0]  in_row,
    input  wire logic [IW-1:0]  in_col,
    input  wire logic [VW-1:0]  in_value,
    input  wire smma_pkg::cmd_t cmd,
    output smma_pkg::sts_t      sts,
    input  wire logic           out_ready,
    output logic                out_valid,
    output logic [2:0]          out_status,
    output logic [IW-1:0]       out_row,
    output logic [IW-1:0]       out_col,
    output logic [VW:0]         out_value,
    output logic                out_entry_valid,
    output logic                out_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int EW = 2 * IW + VW;
    localparam int KW = 2 * IW;

    // configuration
    logic [DW-1:0] rows_first_reg, cols_first_reg, rows_second_reg, cols_second_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_first_reg  <= '0;
            cols_first_reg  <= '0;
            rows_second_reg <= '0;
            cols_second_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                smma_pkg::CFG_ROWS_FIRST:  rows_first_reg  <= cfg_data;
                smma_pkg::CFG_COLS_FIRST:  cols_first_reg  <= cfg_data;
                smma_pkg::CFG_ROWS_SECOND: rows_second_reg <= cfg_data;
                default:                   cols_second_reg <= cfg_data;
            endcase
        end
    end

    // captured request
    logic [1:0]    req_kind_reg;
    logic [IW-1:0] req_row_reg, req_col_reg;
    logic [VW-1:0] req_value_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_kind_reg  <= in_req_type;
            req_row_reg   <= in_row;
            req_col_reg   <= in_col;
            req_value_reg <= in_value;
        end
    end

    logic          sel_second;
    logic [KW-1:0] req_key;
    assign sel_second = (req_kind_reg == smma_pkg::REQ_LOAD_SECOND);
    assign req_key    = {req_row_reg, req_col_reg};

    // counters and indexes
    logic [CW-1:0] cnt_a_reg, cnt_b_reg, idx_reg, pos_reg, a_reg, b_reg;
    logic [CW-1:0] sel_cnt;
    assign sel_cnt = sel_second ? cnt_b_reg : cnt_a_reg;

    // table RAMs
    logic [EW-1:0] rd_a, rd_b, sel_rd, wdata;
    logic [AW-1:0] raddr_a, raddr_b, rload, waddr;
    logic          re, we_a, we_b;

    assign rload   = cmd.shift_read ? AW'(idx_reg - CW'(1)) : idx_reg[AW-1:0];
    assign raddr_a = cmd.mrg_read ? a_reg[AW-1:0] : rload;
    assign raddr_b = cmd.mrg_read ? b_reg[AW-1:0] : rload;
    assign re      = cmd.scan_read | cmd.shift_read | cmd.mrg_read;
    assign sel_rd  = sel_second ? rd_b : rd_a;
    assign waddr   = cmd.insert ? pos_reg[AW-1:0] : idx_reg[AW-1:0];
    assign wdata   = cmd.insert ? {req_key, req_value_reg} : sel_rd;
    assign we_a    = (cmd.insert | cmd.shift_write) & !sel_second;
    assign we_b    = (cmd.insert | cmd.shift_write) & sel_second;

    smma_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram_first (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr_a),
        .rdata (rd_a)
    );

    smma_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram_second (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr_b),
        .rdata (rd_b)
    );

    // merge selection
    logic [KW-1:0] key_a, key_b, mrg_key;
    logic          a_ok, b_ok, take_both, take_a;
    logic [VW:0]   val_a, val_b, mrg_val;

    assign key_a     = rd_a[EW-1:VW];
    assign key_b     = rd_b[EW-1:VW];
    assign val_a     = {rd_a[VW-1], rd_a[VW-1:0]};
    assign val_b     = {rd_b[VW-1], rd_b[VW-1:0]};
    assign a_ok      = a_reg < cnt_a_reg;
    assign b_ok      = b_reg < cnt_b_reg;
    assign take_both = a_ok && b_ok && (key_a == key_b);
    assign take_a    = !take_both && (!b_ok || (a_ok && (key_a < key_b)));

    always_comb
    begin
        priority if (take_both)
        begin
            mrg_key = key_a;
            mrg_val = val_a + val_b;
        end
        else if (take_a)
        begin
            mrg_key = key_a;
            mrg_val = val_a;
        end
        else
        begin
            mrg_key = key_b;
            mrg_val = val_b;
        end
    end

    // pending merge entry
    logic [KW-1:0] pend_key_reg;
    logic [VW:0]   pend_val_reg;
    logic          pend_valid_reg;

    // counters, indexes and pending entry control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            idx_reg        <= '0;
            pos_reg        <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_tables)
            begin
                cnt_a_reg <= '0;
                cnt_b_reg <= '0;
            end
            if (cmd.insert)
            begin
                if (sel_second)
                begin
                    cnt_b_reg <= cnt_b_reg + CW'(1);
                end
                else
                begin
                    cnt_a_reg <= cnt_a_reg + CW'(1);
                end
            end
            priority if (cmd.idx_zero)
            begin
                idx_reg <= '0;
            end
            else if (cmd.set_pos)
            begin
                pos_reg <= idx_reg;
                idx_reg <= sel_cnt;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            else if (cmd.idx_dec)
            begin
                idx_reg <= idx_reg - CW'(1);
            end
            if (cmd.mrg_init)
            begin
                a_reg          <= '0;
                b_reg          <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.mrg_step)
            begin
                if (take_both || take_a)
                begin
                    a_reg <= a_reg + CW'(1);
                end
                if (take_both || !take_a)
                begin
                    b_reg <= b_reg + CW'(1);
                end
                if (mrg_val != '0)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mrg_step && (mrg_val != '0))
        begin
            pend_key_reg <= mrg_key;
            pend_val_reg <= mrg_val;
        end
    end

    // output register
    logic out_valid_reg, out_free;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit != smma_pkg::EMIT_NONE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.emit)
            smma_pkg::EMIT_STATUS:
            begin
                out_status      <= cmd.emit_code;
                out_row         <= '0;
                out_col         <= '0;
                out_value       <= '0;
                out_entry_valid <= 1'b0;
                out_last        <= 1'b1;
            end
            smma_pkg::EMIT_PEND, smma_pkg::EMIT_FINAL:
            begin
                out_status      <= smma_pkg::STS_OK;
                out_row         <= pend_valid_reg ? pend_key_reg[KW-1:IW] : '0;
                out_col         <= pend_valid_reg ? pend_key_reg[IW-1:0] : '0;
                out_value       <= pend_valid_reg ? pend_val_reg : '0;
                out_entry_valid <= pend_valid_reg;
                out_last        <= (cmd.emit == smma_pkg::EMIT_FINAL);
            end
            default:
            begin
            end
        endcase
    end

    // status toward the controller
    logic [DW-1:0] dim_rows, dim_cols;
    assign dim_rows = sel_second ? rows_second_reg : rows_first_reg;
    assign dim_cols = sel_second ? cols_second_reg : cols_first_reg;

    always_comb
    begin
        sts.req_kind      = req_kind_reg;
        sts.range_bad     = ({1'b0, req_row_reg} >= dim_rows)
                          || ({1'b0, req_col_reg} >= dim_cols);
        sts.value_zero    = (req_value_reg == '0);
        sts.dims_mismatch = (rows_first_reg != rows_second_reg)
                          || (cols_first_reg != cols_second_reg);
        sts.scan_more     = idx_reg < sel_cnt;
        sts.key_eq        = sel_rd[EW-1:VW] == req_key;
        sts.key_gt        = sel_rd[EW-1:VW] > req_key;
        sts.tab_full      = sel_cnt == CW'(CAPACITY);
        sts.sh_more       = idx_reg > pos_reg;
        sts.mrg_more      = a_ok || b_ok;
        sts.mrg_nonzero   = mrg_val != '0;
        sts.pend_valid    = pend_valid_reg;
        sts.out_free      = out_free;
    end

endmodule

`default_nettype wire

>>> bench/sparse_matrix_merge_add_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_matrix_merge_add_tb: regression for the sparse matrix merge-add block
// Loads both entry tables, issues add and clear requests under random
// backpressure and source gaps, and checks every output transaction field by
// field against a behavioral model of the two sorted tables and their merge.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_matrix_merge_add_tb;

    localparam int IN_W  = 32;
    localparam int OUT_W = 40;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [16:0] value;
        logic        valid;
        logic        last;
    } sum_item_t;

    typedef struct packed {
        logic [7:0]         row;
        logic [7:0]         col;
        logic signed [16:0] value;
    } node_t;

    // directed stimulus row: request, fields, optional typed-in status
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [15:0] value;
        logic        has_sts;
        logic [2:0]  sts;
    } req_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_addr = '0;
    logic [8:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic [3:0] m_tuser;
    logic m_tlast;

    sparse_matrix_merge_add uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #5 clk = ~clk;

    // model state
    node_t    tab_a[$];
    node_t    tab_b[$];
    logic [8:0] dims[4];
    sum_item_t  sums_due[$];

    int errors = 0;
    int results_seen = 0;
    int adds_sent = 0;
    int cycles = 0;
    int rx_wait = 0;
    bit rx_on = 1'b0;

    task automatic report_mismatch(input string what, input sum_item_t got,
                                   input sum_item_t want);
        errors++;
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    endtask

    function automatic logic [2:0] table_load(ref node_t t[$], input logic [8:0] nr,
                                              input logic [8:0] nc, input node_t n);
        int p;
        p = 0;
        if ({1'b0, n.row} >= nr || {1'b0, n.col} >= nc) return smma_pkg::STS_RANGE;
        if (n.value == 0) return smma_pkg::STS_ZERO;
        while (p < t.size() && {t[p].row, t[p].col} < {n.row, n.col}) p++;
        if (p < t.size() && {t[p].row, t[p].col} == {n.row, n.col})
            return smma_pkg::STS_DUP;
        if (t.size() >= smma_pkg::CAPACITY) return smma_pkg::STS_FULL;
        t.insert(p, n);
        return smma_pkg::STS_OK;
    endfunction

    function automatic sum_item_t status_only(input logic [2:0] s);
        sum_item_t r;
        r = '0;
        r.status = s;
        r.last = 1'b1;
        return r;
    endfunction

    // work out the results of one request and queue them
    task automatic predict_request(input logic [1:0] kind, input logic [IN_W-1:0] d);
        node_t n;
        sum_item_t r;
        int a, b, first_new;
        logic signed [16:0] v;
        node_t s;
        n.row = d[7:0];
        n.col = d[15:8];
        n.value = {d[31], d[31:16]};
        case (kind)
            smma_pkg::REQ_LOAD_FIRST:
                sums_due.push_back(status_only(table_load(tab_a,
                                   dims[smma_pkg::CFG_ROWS_FIRST],
                                   dims[smma_pkg::CFG_COLS_FIRST], n)));
            smma_pkg::REQ_LOAD_SECOND:
                sums_due.push_back(status_only(table_load(tab_b,
                                   dims[smma_pkg::CFG_ROWS_SECOND],
                                   dims[smma_pkg::CFG_COLS_SECOND], n)));
            smma_pkg::REQ_CLEAR:
            begin
                tab_a.delete();
                tab_b.delete();
                sums_due.push_back(status_only(smma_pkg::STS_OK));
            end
            default:
            begin
                if (dims[smma_pkg::CFG_ROWS_FIRST] != dims[smma_pkg::CFG_ROWS_SECOND] ||
                    dims[smma_pkg::CFG_COLS_FIRST] != dims[smma_pkg::CFG_COLS_SECOND])
                begin
                    sums_due.push_back(status_only(smma_pkg::STS_MISMATCH));
                end
                else
                begin
                    a = 0;
                    b = 0;
                    first_new = sums_due.size();
                    while (a < tab_a.size() || b < tab_b.size())
                    begin
                        if (a < tab_a.size() && b < tab_b.size() &&
                            {tab_a[a].row, tab_a[a].col} == {tab_b[b].row, tab_b[b].col})
                        begin
                            s = tab_a[a];
                            v = tab_a[a].value + tab_b[b].value;
                            a++;
                            b++;
                        end
                        else if (b >= tab_b.size() || (a < tab_a.size() &&
                                 {tab_a[a].row, tab_a[a].col} < {tab_b[b].row, tab_b[b].col}))
                        begin
                            s = tab_a[a];
                            v = s.value;
                            a++;
                        end
                        else
                        begin
                            s = tab_b[b];
                            v = s.value;
                            b++;
                        end
                        if (v != 0)
                        begin
                            r = '0;
                            r.row = s.row;
                            r.col = s.col;
                            r.value = v;
                            r.valid = 1'b1;
                            sums_due.push_back(r);
                        end
                    end
                    if (sums_due.size() == first_new)
                        sums_due.push_back(status_only(smma_pkg::STS_OK));
                    else
                        sums_due[sums_due.size()-1].last = 1'b1;
                end
            end
        endcase
    endtask

    // send one request after a random idle gap, predicting at acceptance
    task automatic send_request(input logic [1:0] kind, input logic [7:0] row,
                                input logic [7:0] col, input logic [15:0] value);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser <= kind;
        s_tdata <= {value, col, row};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_request(kind, {value, col, row});
        if (kind == smma_pkg::REQ_ADD) adds_sent++;
    endtask

    // send one table row and hold the model to its typed-in status
    task automatic send_row(input req_row_t q);
        send_request(q.kind, q.row, q.col, q.value);
        if (q.has_sts && sums_due[sums_due.size()-1].status != q.sts)
            report_mismatch("directed status", sums_due[sums_due.size()-1],
                            status_only(q.sts));
    endtask

    // write a register while idle
    task automatic write_dim(input logic [1:0] idx, input logic [8:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= v;
        dims[idx] = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sums_due.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic set_dims(input logic [8:0] r1, input logic [8:0] c1,
                            input logic [8:0] r2, input logic [8:0] c2);
        drain();
        write_dim(smma_pkg::CFG_ROWS_FIRST, r1);
        write_dim(smma_pkg::CFG_COLS_FIRST, c1);
        write_dim(smma_pkg::CFG_ROWS_SECOND, r2);
        write_dim(smma_pkg::CFG_COLS_SECOND, c2);
    endtask

    // receiver: waits a drawn number of cycles before each transaction
    always @(negedge clk)
    begin
        if (rx_on)
        begin
            if (rx_wait > 0)
            begin
                m_tready <= 1'b0;
                rx_wait = rx_wait - 1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        sum_item_t got;
        sum_item_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("sparse_matrix_merge_add regression: fail");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            rx_wait = $urandom_range(0, 17);
            got.status = m_tuser[2:0];
            got.valid  = m_tuser[3];
            got.row    = m_tdata[7:0];
            got.col    = m_tdata[15:8];
            got.value  = m_tdata[32:16];
            got.last   = m_tlast;
            results_seen++;
            if (sums_due.size() == 0)
            begin
                report_mismatch("unexpected transaction", got, '0);
            end
            else
            begin
                want = sums_due.pop_front();
                if (got.status != want.status) report_mismatch("status", got, want);
                if (got.row != want.row) report_mismatch("row", got, want);
                if (got.col != want.col) report_mismatch("col", got, want);
                if (got.value != want.value) report_mismatch("value", got, want);
                if (got.valid != want.valid) report_mismatch("entry_valid", got, want);
                if (got.last != want.last) report_mismatch("last", got, want);
            end
        end
    end

    req_row_t directed[$];

    initial
    begin
        int k, n, mode;
        logic [7:0] r, c;
        logic [15:0] v;
        logic [8:0] dr, dc;
        dims[0] = '0; dims[1] = '0; dims[2] = '0; dims[3] = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        rx_on = 1'b1;

        // dims at reset are zero: every load is out of range, add matches
        directed = '{
            '{smma_pkg::REQ_LOAD_FIRST, 8'd0, 8'd0, 16'd5, 1'b1, smma_pkg::STS_RANGE},
            '{smma_pkg::REQ_ADD, 8'd0, 8'd0, 16'd0, 1'b1, smma_pkg::STS_OK},
            '{smma_pkg::REQ_CLEAR, 8'd0, 8'd0, 16'd0, 1'b1, smma_pkg::STS_OK}
        };
        foreach (directed[i])
            send_row(directed[i]);

        // full extent: extremes of indexes and values, zero, duplicate, sums
        set_dims(9'd256, 9'd256, 9'd256, 9'd256);
        directed = '{
            '{smma_pkg::REQ_LOAD_FIRST, 8'd255, 8'd255, 16'h7fff, 1'b1, smma_pkg::STS_OK},
            '{smma_pkg::REQ_LOAD_SECOND, 8'd255, 8'd255, 16'h7fff, 1'b1, smma_pkg::STS_OK},
            '{smma_pkg::REQ_LOAD_FIRST, 8'd0, 8'd0, 16'h8000, 1'b1, smma_pkg::STS_OK},
            '{smma_pkg::REQ_LOAD_SECOND, 8'd0, 8'd0, 16'h8000, 1'b1, smma_pkg::STS_OK},
            '{smma_pkg::REQ_LOAD_FIRST, 8'd1, 8'd2, 16'd0, 1'b1, smma_pkg::STS_ZERO},
            '{smma_pkg::REQ_LOAD_FIRST, 8'd0, 8'd0, 16'd9, 1'b1, smma_pkg::STS_DUP},
            '{smma_pkg::REQ_LOAD_FIRST, 8'd7, 8'd3, 16'd100, 1'b0, smma_pkg::STS_OK},
            '{smma_pkg::REQ_LOAD_SECOND, 8'd7, 8'd3, 16'hff9c, 1'b0, smma_pkg::STS_OK},
            '{smma_pkg::REQ_LOAD_SECOND, 8'd3, 8'd200, 16'haaaa, 1'b0, smma_pkg::STS_OK},
            '{smma_pkg::REQ_LOAD_FIRST, 8'd200, 8'd3, 16'h5555, 1'b0, smma_pkg::STS_OK},
            '{smma_pkg::REQ_ADD, 8'd0, 8'd0, 16'd0, 1'b0, smma_pkg::STS_OK},
            '{smma_pkg::REQ_CLEAR, 8'd0, 8'd0, 16'd0, 1'b1, smma_pkg::STS_OK},
            '{smma_pkg::REQ_ADD, 8'd0, 8'd0, 16'd0, 1'b1, smma_pkg::STS_OK}
        };
        foreach (directed[i])
            send_row(directed[i]);

        // mismatch and small-range rejection
        set_dims(9'd4, 9'd5, 9'd4, 9'd6);
        send_request(smma_pkg::REQ_LOAD_FIRST, 8'd4, 8'd0, 16'd1);
        send_request(smma_pkg::REQ_LOAD_FIRST, 8'd0, 8'd5, 16'd1);
        send_request(smma_pkg::REQ_ADD, 8'd0, 8'd0, 16'd0);

        // fill a table past capacity
        set_dims(9'd8, 9'd8, 9'd8, 9'd8);
        for (k = 0; k < 34; k++)
            send_request(smma_pkg::REQ_LOAD_FIRST, 8'(k / 8), 8'(k % 8), 16'(k + 1));
        send_request(smma_pkg::REQ_ADD, 8'd0, 8'd0, 16'd0);
        send_request(smma_pkg::REQ_CLEAR, 8'd0, 8'd0, 16'd0);

        // random phases: mostly loads into small grids so keys collide
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin dr = 9'd4; dc = 9'd4; end
                1: begin dr = 9'd256; dc = 9'd256; end
                2: begin dr = 9'd1; dc = 9'd1; end
                3: begin dr = 9'd16; dc = 9'd3; end
                default: begin dr = 9'($urandom_range(1, 256));
                               dc = 9'($urandom_range(1, 256)); end
            endcase
            if ($urandom_range(0, 5) == 0)
                set_dims(dr, dc, dr, 9'($urandom_range(0, 256)));
            else
                set_dims(dr, dc, dr, dc);
            n = 24 + $urandom_range(0, 10);
            for (k = 0; k < n; k++)
            begin
                mode = $urandom_range(0, 19);
                r = (ph == 1) ? 8'($urandom) : 8'($urandom_range(0, dr + 1));
                c = (ph == 1) ? 8'($urandom) : 8'($urandom_range(0, dc + 1));
                v = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
                if ($urandom_range(0, 4) == 0) v = 16'($signed(16'($urandom_range(0, 6))) - 3);
                if (mode < 8)       send_request(smma_pkg::REQ_LOAD_FIRST, r, c, v);
                else if (mode < 16) send_request(smma_pkg::REQ_LOAD_SECOND, r, c, v);
                else if (mode < 19) send_request(smma_pkg::REQ_ADD, r, c, v);
                else                send_request(smma_pkg::REQ_CLEAR, r, c, v);
            end
            send_request(smma_pkg::REQ_ADD, 8'($urandom), 8'($urandom), 16'($urandom));
        end

        drain();
        $display("covered %0d add requests, %0d output transactions checked",
                 adds_sent, results_seen);
        if (errors == 0)
            $display("sparse_matrix_merge_add regression: pass");
        else
            $display("sparse_matrix_merge_add regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
